[design/irtl_pkg.sv]
// shared constants and the queue item type for the ip range table lookup
package irtl_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int SLOT_W      = 12;
    localparam int ADDR_W      = 32;
    localparam int COUNT_W     = 13;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // one classified transaction waiting between front and back
    typedef struct packed {
        logic              is_lookup;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] word_a;     // range start on a load, query address on a lookup
        logic [ADDR_W-1:0] word_b;     // range end on a load
    } item_t;

endpackage

[design/irtl_front.sv]
// input side: accepts transactions, drops out-of-range loads, queues the rest
module irtl_front #(
    parameter int TABLE_DEPTH = irtl_pkg::TABLE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         command,
    input  logic [irtl_pkg::SLOT_W-1:0]  entry_index,
    input  logic [irtl_pkg::ADDR_W-1:0]  range_start,
    input  logic [irtl_pkg::ADDR_W-1:0]  range_end,
    input  logic [irtl_pkg::ADDR_W-1:0]  query_address,
    output logic                         q_valid,
    output irtl_pkg::item_t              q_item,
    input  logic                         q_pop
);

    localparam int QDEPTH = 2;

    irtl_pkg::item_t q_mem [QDEPTH];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            keep;
    logic            push;
    irtl_pkg::item_t new_item;

    assign keep = (command == irtl_pkg::CMD_LOOKUP)
               || (32'(entry_index) < 32'(TABLE_DEPTH));

    always_comb
    begin
        new_item.is_lookup = (command == irtl_pkg::CMD_LOOKUP);
        new_item.slot      = entry_index;
        new_item.word_a    = (command == irtl_pkg::CMD_LOOKUP) ? query_address : range_start;
        new_item.word_b    = range_end;
    end

    assign in_ready = (count_reg != 2'(QDEPTH));
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule

[design/irtl_back.sv]
// execution side: range tables, binary search engine and result register
module irtl_back #(
    parameter int TABLE_DEPTH = irtl_pkg::TABLE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [irtl_pkg::COUNT_W-1:0] entry_count,
    input  logic                         q_valid,
    input  irtl_pkg::item_t              q_item,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit,
    output logic [irtl_pkg::SLOT_W-1:0]  matched_entry
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_CHECK  = 3'b100
    } state_t;

    logic [irtl_pkg::ADDR_W-1:0] start_mem [TABLE_DEPTH];
    logic [irtl_pkg::ADDR_W-1:0] end_mem   [TABLE_DEPTH];
    logic [irtl_pkg::ADDR_W-1:0] rd_start_reg;
    logic [irtl_pkg::ADDR_W-1:0] rd_end_reg;

    state_t                      state_reg, state_next;
    logic [CW-1:0]               lo_reg, lo_next;
    logic [CW-1:0]               hp_reg, hp_next;     // one past the upper bound
    logic [AW-1:0]               mid_reg, mid_next;   // entry whose words sit in the read registers
    logic [irtl_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        hit_reg, hit_next;
    logic [irtl_pkg::SLOT_W-1:0] matched_reg, matched_next;

    logic                        rd_en, wr_en;
    logic [AW-1:0]               rd_addr, wr_addr;
    logic [CW-1:0]               n_sat;
    logic [CW:0]                 init_sum;
    logic [AW-1:0]               init_mid;
    logic                        s_eq, s_gt;
    logic [CW-1:0]               mid_ext;
    logic [CW-1:0]               s_lo, s_hp;
    logic [CW:0]                 s_sum;
    logic [AW-1:0]               s_mid;
    logic [AW-1:0]               chk_idx;
    logic                        out_free;
    logic                        range_hit;

    always_comb
    begin
        if (32'(entry_count) > 32'(TABLE_DEPTH))
        begin
            n_sat = CW'(TABLE_DEPTH);
        end
        else
        begin
            n_sat = CW'(entry_count);
        end
    end

    // first probe sits at (n - 1) / 2
    assign init_sum = {1'b0, n_sat} - {{CW{1'b0}}, 1'b1};
    assign init_mid = AW'(init_sum >> 1);

    // one search step from the start word read last cycle
    assign s_eq    = (rd_start_reg == addr_reg);
    assign s_gt    = (rd_start_reg > addr_reg);
    assign mid_ext = CW'(mid_reg);
    assign s_lo    = s_gt ? lo_reg : (mid_ext + CW'(1));
    assign s_hp    = s_gt ? mid_ext : hp_reg;
    assign s_sum   = {1'b0, s_lo} + {1'b0, s_hp} - {{CW{1'b0}}, 1'b1};
    assign s_mid   = AW'(s_sum >> 1);
    assign chk_idx = AW'(s_hp - CW'(1));

    assign range_hit = (addr_reg > rd_start_reg) && (addr_reg <= rd_end_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign wr_addr   = AW'(q_item.slot);

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hp_next        = hp_reg;
        mid_next       = mid_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        hit_next       = hit_reg;
        matched_next   = matched_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = mid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && !q_item.is_lookup)
                begin
                    q_pop = 1'b1;
                    wr_en = 1'b1;
                end
                else if (q_valid && out_free)
                begin
                    // a lookup starts only when its result has a free slot
                    q_pop     = 1'b1;
                    addr_next = q_item.word_a;
                    lo_next   = '0;
                    hp_next   = n_sat;
                    if (n_sat == '0)
                    begin
                        out_valid_next = 1'b1;
                        hit_next       = 1'b0;
                        matched_next   = '0;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = init_mid;
                        mid_next   = init_mid;
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH:
            begin
                if (s_eq)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = 1'b1;
                    matched_next   = irtl_pkg::SLOT_W'(mid_reg);
                    state_next     = ST_IDLE;
                end
                else
                begin
                    lo_next = s_lo;
                    hp_next = s_hp;
                    if (s_lo < s_hp)
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = s_mid;
                        mid_next = s_mid;
                    end
                    else if (s_hp != '0)
                    begin
                        // last entry with a start below the address
                        rd_en      = 1'b1;
                        rd_addr    = chk_idx;
                        mid_next   = chk_idx;
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        hit_next       = 1'b0;
                        matched_next   = '0;
                        state_next     = ST_IDLE;
                    end
                end
            end

            ST_CHECK:
            begin
                out_valid_next = 1'b1;
                hit_next       = range_hit;
                matched_next   = range_hit ? irtl_pkg::SLOT_W'(mid_reg) : '0;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hp_reg      <= hp_next;
        mid_reg     <= mid_next;
        addr_reg    <= addr_next;
        hit_reg     <= hit_next;
        matched_reg <= matched_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_mem[wr_addr] <= q_item.word_a;
            end_mem[wr_addr]   <= q_item.word_b;
        end
        if (rd_en)
        begin
            rd_start_reg <= start_mem[rd_addr];
            rd_end_reg   <= end_mem[rd_addr];
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign matched_entry = matched_reg;

endmodule

[design/ip_range_table_lookup_top.sv]
// top level: entry count register, front queue and search back end
// a load is written into both tables as the idle back end pops it; a lookup leaves the queue only
// when the result register is free, binary-searches the start words, one probe per cycle on the
// single read port, and may then read the last entry with a start below the address to check its end
// word; the back end takes no new item from the queue until that lookup's result is registered
// one lookup is in the search engine at a time; a two-entry queue keeps taking transactions meanwhile
// reset clears the queue, the engine state, the result valid flag and entry_count; table contents
// stay undefined until loaded
module ip_range_table_lookup_top #(
    parameter int TABLE_DEPTH = irtl_pkg::TABLE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [irtl_pkg::COUNT_W-1:0] cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         command,
    input  logic [irtl_pkg::SLOT_W-1:0]  entry_index,
    input  logic [irtl_pkg::ADDR_W-1:0]  range_start,
    input  logic [irtl_pkg::ADDR_W-1:0]  range_end,
    input  logic [irtl_pkg::ADDR_W-1:0]  query_address,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit,
    output logic [irtl_pkg::SLOT_W-1:0]  matched_entry
);

    logic [irtl_pkg::COUNT_W-1:0] entry_count_reg, entry_count_next;
    logic                         q_valid;
    logic                         q_pop;
    irtl_pkg::item_t              q_item;

    assign cfg_ready        = 1'b1;
    assign entry_count_next = (cfg_valid && cfg_ready) ? cfg_data : entry_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
        end
    end

    irtl_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .entry_index   (entry_index),
        .range_start   (range_start),
        .range_end     (range_end),
        .query_address (query_address),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    irtl_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .entry_count   (entry_count_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit           (hit),
        .matched_entry (matched_entry)
    );

    // the back end never pops from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("queue popped while empty");

    // a lookup only starts when the result register can take its result
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_item.is_lookup) |-> (!out_valid || out_ready))
        else $error("lookup started with result register blocked");

    // a miss always reports slot zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (matched_entry == '0))
        else $error("miss with nonzero matched entry");

endmodule

[tb/ip_range_table_lookup_checker.sv]
`timescale 1ns / 1ps
// checker for the ip range table lookup: mirrors the tables, predicts each lookup, compares results
module ip_range_table_lookup_checker
    import irtl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               command,
    input  logic [SLOT_W-1:0]  entry_index,
    input  logic [ADDR_W-1:0]  range_start,
    input  logic [ADDR_W-1:0]  range_end,
    input  logic [ADDR_W-1:0]  query_address,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               hit,
    input  logic [SLOT_W-1:0]  matched_entry,
    output int                 fail_count,
    output int                 lookups_in_flight
);

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } match_t;

    logic [ADDR_W-1:0]  range_lo_mem [TABLE_DEPTH];
    logic [ADDR_W-1:0]  range_hi_mem [TABLE_DEPTH];
    logic [COUNT_W-1:0] entry_count;
    match_t             match_q [$];

    initial
    begin
        fail_count        = 0;
        lookups_in_flight = 0;
    end

    // binary search over the range starts, then a bounds check on the last start below
    function automatic match_t search_ranges(logic [ADDR_W-1:0] addr);
        int     span;
        int     lo;
        int     hi;
        int     mid;
        match_t res;
        span = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
        lo   = 0;
        hi   = span - 1;
        res  = '0;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (range_lo_mem[mid] == addr)
            begin
                res.hit  = 1'b1;
                res.slot = SLOT_W'(mid);
                return res;
            end
            if (range_lo_mem[mid] > addr)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        if (hi >= 0 && addr > range_lo_mem[hi] && addr <= range_hi_mem[hi])
        begin
            res.hit  = 1'b1;
            res.slot = SLOT_W'(hi);
        end
        return res;
    endfunction

    task automatic report_field(string field, int unsigned want, int unsigned got);
        fail_count++;
        $error("%s: expected %0d, actual %0d", field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        match_t want;
        if (!rst_n)
        begin
            entry_count = '0;
            match_q.delete();
            lookups_in_flight = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                entry_count = cfg_data;
            if (in_valid && in_ready)
            begin
                if (command == CMD_LOAD)
                begin
                    range_lo_mem[entry_index] = range_start;
                    range_hi_mem[entry_index] = range_end;
                end
                else
                    match_q.push_back(search_ranges(query_address));
            end
            if (out_valid && out_ready)
            begin
                if (match_q.size() == 0)
                begin
                    fail_count++;
                    $error("result transaction with no lookup pending: hit %0d matched_entry %0d",
                           hit, matched_entry);
                end
                else
                begin
                    want = match_q.pop_front();
                    if (hit !== want.hit)
                        report_field("hit", 32'(want.hit), 32'(hit));
                    if (matched_entry !== want.slot)
                        report_field("matched_entry", 32'(want.slot), 32'(matched_entry));
                end
            end
            lookups_in_flight = match_q.size();
        end
    end

endmodule

[tb/ip_range_table_lookup_top_tb.sv]
`timescale 1ns / 1ps
// testbench top: stimulus for the ip range table lookup and the final verdict
module ip_range_table_lookup_top_tb;
    import irtl_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 32;
    localparam int RANDOM_ITEMS = 950;

    typedef enum int {SHAPE_SPREAD, SHAPE_DENSE, SHAPE_SHUFFLED} table_shape_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               command;
    logic [SLOT_W-1:0]  entry_index;
    logic [ADDR_W-1:0]  range_start;
    logic [ADDR_W-1:0]  range_end;
    logic [ADDR_W-1:0]  query_address;
    logic               out_valid;
    logic               out_ready;
    logic               hit;
    logic [SLOT_W-1:0]  matched_entry;
    int                 fail_count;
    int                 lookups_in_flight;

    int                 stalled_cycles;
    bit                 steady_sender;
    int                 live_entries;
    logic [ADDR_W-1:0]  plan_lo [TABLE_DEPTH];
    logic [ADDR_W-1:0]  plan_hi [TABLE_DEPTH];

    ip_range_table_lookup_top u_top (.*);

    ip_range_table_lookup_checker u_checker (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(logic cmd, logic [SLOT_W-1:0] slot, logic [ADDR_W-1:0] lo,
                             logic [ADDR_W-1:0] hi, logic [ADDR_W-1:0] addr);
        int gap;
        gap = steady_sender ? 0 : pick_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      = 1'b1;
        command       = cmd;
        entry_index   = slot;
        range_start   = lo;
        range_end     = hi;
        query_address = addr;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic load_slot(logic [SLOT_W-1:0] slot, logic [ADDR_W-1:0] lo,
                             logic [ADDR_W-1:0] hi);
        plan_lo[slot] = lo;
        plan_hi[slot] = hi;
        send_item(CMD_LOAD, slot, lo, hi, $urandom());
    endtask

    task automatic lookup(logic [ADDR_W-1:0] addr);
        send_item(CMD_LOOKUP, SLOT_W'($urandom()), $urandom(), $urandom(), addr);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (lookups_in_flight != 0) @(negedge clk);
        // loads give no result and may still be in the back end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_count(logic [COUNT_W-1:0] value);
        wait_idle();
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid    = 1'b0;
        live_entries = (value > TABLE_DEPTH) ? TABLE_DEPTH : int'(value);
    endtask

    task automatic build_table(int n, table_shape_t shape);
        longint            step;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        int                r;
        step = 64'h1_0000_0000 / ((n > 0) ? n : 1);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            case (shape)
                SHAPE_SPREAD:
                begin
                    lo = ADDR_W'(longint'(i) * step + $urandom_range(0, 32'(step / 2)));
                    // now and then repeat the previous start
                    if (i > 0 && $urandom_range(0, 19) == 0)
                        lo = plan_lo[i - 1];
                    if (r < 55)
                        hi = lo + $urandom_range(0, 32'(step / 2 - 1));
                    else if (r < 70)
                        hi = lo;
                    else if (r < 82)
                        hi = lo - $urandom_range(1, 1000);
                    else if (r < 92)
                        hi = lo + ADDR_W'(step);
                    else
                        hi = '1;
                end
                SHAPE_DENSE:
                begin
                    lo = ADDR_W'(i * 3 + $urandom_range(0, 1));
                    hi = (r < 15) ? lo - 1 : lo + $urandom_range(0, 2);
                end
                default:
                begin
                    lo = $urandom();
                    hi = (r < 50) ? lo + $urandom_range(0, 65535) : $urandom();
                end
            endcase
            load_slot(SLOT_W'(i), lo, hi);
        end
    endtask

    // start word of a slot on a full-depth probe path, ascending with the slot
    function automatic logic [ADDR_W-1:0] path_start(int slot);
        return ADDR_W'(slot) << 20;
    endfunction

    // full-depth search paths that always step down or always step up
    task automatic walk_probe_paths(bit load_them);
        int lo;
        int hi;
        int mid;
        for (int dir = 0; dir < 2; dir++)
        begin
            lo = 0;
            hi = TABLE_DEPTH - 1;
            while (lo <= hi)
            begin
                mid = (lo + hi) / 2;
                if (load_them)
                    load_slot(SLOT_W'(mid), path_start(mid), path_start(mid) | 32'h000F_FFFF);
                else
                    lookup(path_start(mid));
                if (dir == 0)
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
        end
    endtask

    // aim near the edges of a live range most of the time
    function automatic logic [ADDR_W-1:0] aim_query();
        int                k;
        int                r;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        r = $urandom_range(0, 99);
        if (live_entries == 0 || r < 12)
            return $urandom();
        if (r < 15)
            return '0;
        if (r < 18)
            return '1;
        k  = $urandom_range(0, live_entries - 1);
        lo = plan_lo[k];
        hi = plan_hi[k];
        if (r < 35)
            return lo;
        if (r < 45)
            return lo + 1;
        if (r < 55)
            return lo - 1;
        if (r < 68)
            return hi;
        if (r < 78)
            return hi + 1;
        return lo + (hi - lo) / 2;
    endfunction

    initial
    begin : sink_stalls
        int span;
        out_ready = 1'b0;
        forever
        begin
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
            @(negedge clk);
            out_ready = 1'b1;
            repeat (span - 1) @(negedge clk);
            span = pick_gap();
            if (span != 0)
            begin
                @(negedge clk);
                out_ready = 1'b0;
                repeat (span - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready)
            || (out_valid && out_ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= IDLE_LIMIT)
        begin
            $display("ip_range_table_lookup_top_tb NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        int           r;
        int           n;
        int           m;
        int           random_items;
        table_shape_t shape;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        command        = CMD_LOAD;
        entry_index    = '0;
        range_start    = '0;
        range_end      = '0;
        query_address  = '0;
        stalled_cycles = 0;
        steady_sender  = 1'b0;
        live_entries   = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // empty table always misses
        set_count('0);
        lookup('0);
        lookup('1);

        // small sorted table, slot 2 holds an inverted range
        load_slot(SLOT_W'(0), 32'h0000_0000, 32'h0000_00FF);
        load_slot(SLOT_W'(1), 32'h0A00_0000, 32'h0AFF_FFFF);
        load_slot(SLOT_W'(2), 32'h8000_0000, 32'h7FFF_0000);
        load_slot(SLOT_W'(3), 32'hC0A8_0000, 32'hC0A8_FFFF);
        load_slot(SLOT_W'(4), 32'hFFFF_FF00, 32'hFFFF_FFFF);
        load_slot(SLOT_W'(TABLE_DEPTH - 1), '1, '0);
        set_count(COUNT_W'(5));
        lookup(32'h0000_0000);
        lookup(32'h0000_00FF);
        lookup(32'h0000_0100);
        lookup(32'h0A12_3456);
        lookup(32'h0B00_0000);
        lookup(32'h8000_0000);
        lookup(32'h8000_0001);
        lookup(32'hC0A8_FFFF);
        lookup(32'hC0A9_0000);
        lookup(32'hFFFF_FF00);
        lookup(32'hFFFF_FFFF);

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                n = 0;
            else if (r < 55)
                n = $urandom_range(1, 8);
            else if (r < 90)
                n = $urandom_range(9, 40);
            else
                n = $urandom_range(41, 160);
            steady_sender = ($urandom_range(0, 4) == 0);
            set_count(COUNT_W'(n));
            r     = $urandom_range(0, 99);
            shape = (r < 65) ? SHAPE_SPREAD : (r < 85) ? SHAPE_DENSE : SHAPE_SHUFFLED;
            build_table(n, shape);
            random_items += n;
            m = $urandom_range(8, 40);
            repeat (m)
            begin
                // stray loads break the ordering now and then
                if ($urandom_range(0, 19) == 0)
                    load_slot(SLOT_W'($urandom()), $urandom(), $urandom());
                else
                    lookup(aim_query());
                random_items++;
            end
        end

        // full-depth count, then a count above the table depth, probing only loaded slots
        steady_sender = 1'b0;
        walk_probe_paths(1'b1);
        set_count(COUNT_W'(TABLE_DEPTH));
        lookup('0);
        lookup('1);
        walk_probe_paths(1'b0);
        set_count('1);
        lookup('0);
        lookup('1);
        walk_probe_paths(1'b0);

        wait_idle();
        if (fail_count == 0)
            $display("ip_range_table_lookup_top_tb OK");
        else
            $display("ip_range_table_lookup_top_tb NOT OK");
        $finish;
    end

endmodule
